>>> src/epoch_seconds_to_utc_date_top_assert.svh
// Assertion macros for the epoch seconds to UTC date block.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef EPOCH_SECONDS_TO_UTC_DATE_TOP_ASSERT_SVH
`define EPOCH_SECONDS_TO_UTC_DATE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define ESUTC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("esutc assertion failed");
// Check a property on every clock edge, reset included.
`define ESUTC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("esutc assertion failed");
`else
`define ESUTC_ASSERT(lbl, clk, rst_n, prop)
`define ESUTC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> src/esutc_pkg.sv
// Shared types, constants and calendar functions for the epoch to UTC date block.
// Depends on nothing.
`default_nettype none

package esutc_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEC_MUL,
    ST_SEC_REM,
    ST_MIN_MUL,
    ST_MIN_REM,
    ST_HR_MUL,
    ST_HR_REM,
    ST_WD_MUL,
    ST_WD_REM,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_e;

  // Reciprocal constants: floor(x * K >> SH) == floor(x / d) over the input range.
  localparam logic [31:0] K_DIV60  = 32'd2290649225;
  localparam int          SH_DIV60 = 37;
  localparam logic [31:0] K_DIV24  = 32'd2863311531;
  localparam int          SH_DIV24 = 36;
  localparam logic [31:0] K_DIV7   = 32'd613566757;
  localparam int          SH_DIV7  = 32;

  localparam logic [30:0] EPOCH_WEEKDAY = 31'd4;
  localparam logic [7:0]  EPOCH_YEAR_OFS = 8'd70;  // 1970 - 1900
  localparam logic [3:0]  LAST_MONTH = 4'd11;
  localparam logic [3:0]  FEBRUARY = 4'd1;

  // Year given as offset from 1900; 1900 and 2100 are century non-leap years.
  function automatic logic is_leap(input logic [7:0] yo);
    return (yo[1:0] == 2'b00) && (yo != 8'd0) && (yo != 8'd200);
  endfunction

  function automatic logic [8:0] year_len(input logic [7:0] yo);
    return is_leap(yo) ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [8:0] month_len(input logic [3:0] mon, input logic leap);
    logic [8:0] len;
    case (mon)
      4'd0:    len = 9'd31;
      4'd1:    len = leap ? 9'd29 : 9'd28;
      4'd2:    len = 9'd31;
      4'd3:    len = 9'd30;
      4'd4:    len = 9'd31;
      4'd5:    len = 9'd30;
      4'd6:    len = 9'd31;
      4'd7:    len = 9'd31;
      4'd8:    len = 9'd30;
      4'd9:    len = 9'd31;
      4'd10:   len = 9'd30;
      4'd11:   len = 9'd31;
      default: len = 9'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

>>> src/epoch_seconds_to_utc_date_top.sv
// One shared reciprocal multiplier does the /60, /60, /24 and %7 steps, then one
// shared compare/subtract unit walks years (0..68 whole years past 1970) and
// months (month index 0..11), one step a cycle.
// Next request is taken in the cycle after the result is loaded into the output register.
// Reset (async, active low) clears the sequencer and output valid; no clearing pass.
`default_nettype none

`include "epoch_seconds_to_utc_date_top_assert.svh"

module epoch_seconds_to_utc_date_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [30:0] epoch_seconds_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [5:0]       second_o,
  output logic [5:0]       minute_o,
  output logic [4:0]       hour_o,
  output logic [2:0]       weekday_o,
  output logic [7:0]       years_since_1900_o,
  output logic [8:0]       day_of_year_o,
  output logic [3:0]       month_o,
  output logic [4:0]       day_of_month_o
);

  esutc_pkg::state_e state_q, state_d;
  logic              out_valid_q, out_valid_d;

  logic [30:0] work_q, work_d;
  logic [30:0] quot_q, quot_d;
  logic [5:0]  sec_q, sec_d;
  logic [5:0]  min_q, min_d;
  logic [4:0]  hr_q, hr_d;
  logic [2:0]  wday_q, wday_d;
  logic [7:0]  yo_q, yo_d;
  logic [8:0]  yday_q, yday_d;
  logic [3:0]  mon_q, mon_d;
  logic [4:0]  mday_q, mday_d;

  logic [5:0]  sec_out_q, min_out_q;
  logic [4:0]  hr_out_q, mday_out_q;
  logic [2:0]  wday_out_q;
  logic [7:0]  yo_out_q;
  logic [8:0]  yday_out_q;
  logic [3:0]  mon_out_q;
  logic        load_out;

  // Shared multiplier
  logic [30:0] mul_a;
  logic [31:0] mul_k;
  logic [62:0] prod;
  logic [30:0] quot_c;

  // Shared remainder subtract
  logic [30:0] qd;
  logic [30:0] rem_c;

  // Shared year/month compare and subtract
  logic [8:0]  len_c;
  logic        fits_c;
  logic [30:0] diff_c;

  always_comb begin
    mul_a  = work_q;
    mul_k  = esutc_pkg::K_DIV60;
    quot_c = 31'(prod >> esutc_pkg::SH_DIV60);
    case (state_q)
      esutc_pkg::ST_HR_MUL: begin
        mul_k  = esutc_pkg::K_DIV24;
        quot_c = 31'(prod >> esutc_pkg::SH_DIV24);
      end
      esutc_pkg::ST_WD_MUL: begin
        mul_a  = work_q + esutc_pkg::EPOCH_WEEKDAY;
        mul_k  = esutc_pkg::K_DIV7;
        quot_c = 31'(prod >> esutc_pkg::SH_DIV7);
      end
      default: ;
    endcase
  end

  assign prod = 63'(mul_a) * 63'(mul_k);

  always_comb begin
    case (state_q)
      esutc_pkg::ST_HR_REM: begin
        qd    = (quot_q << 4) + (quot_q << 3);
        rem_c = work_q - qd;
      end
      esutc_pkg::ST_WD_REM: begin
        qd    = (quot_q << 3) - quot_q;
        rem_c = (work_q + esutc_pkg::EPOCH_WEEKDAY) - qd;
      end
      default: begin
        qd    = (quot_q << 6) - (quot_q << 2);
        rem_c = work_q - qd;
      end
    endcase
  end

  assign len_c  = (state_q == esutc_pkg::ST_YEAR) ? esutc_pkg::year_len(yo_q)
                : esutc_pkg::month_len(mon_q, esutc_pkg::is_leap(yo_q));
  assign fits_c = work_q < 31'(len_c);
  assign diff_c = work_q - 31'(len_c);

  assign load_out = (state_q == esutc_pkg::ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    work_d      = work_q;
    quot_d      = quot_q;
    sec_d       = sec_q;
    min_d       = min_q;
    hr_d        = hr_q;
    wday_d      = wday_q;
    yo_d        = yo_q;
    yday_d      = yday_q;
    mon_d       = mon_q;
    mday_d      = mday_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      esutc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          work_d  = epoch_seconds_i;
          state_d = esutc_pkg::ST_SEC_MUL;
        end
      end
      esutc_pkg::ST_SEC_MUL: begin
        quot_d  = quot_c;
        state_d = esutc_pkg::ST_SEC_REM;
      end
      esutc_pkg::ST_SEC_REM: begin
        sec_d   = rem_c[5:0];
        work_d  = quot_q;
        state_d = esutc_pkg::ST_MIN_MUL;
      end
      esutc_pkg::ST_MIN_MUL: begin
        quot_d  = quot_c;
        state_d = esutc_pkg::ST_MIN_REM;
      end
      esutc_pkg::ST_MIN_REM: begin
        min_d   = rem_c[5:0];
        work_d  = quot_q;
        state_d = esutc_pkg::ST_HR_MUL;
      end
      esutc_pkg::ST_HR_MUL: begin
        quot_d  = quot_c;
        state_d = esutc_pkg::ST_HR_REM;
      end
      esutc_pkg::ST_HR_REM: begin
        hr_d    = rem_c[4:0];
        work_d  = quot_q;
        state_d = esutc_pkg::ST_WD_MUL;
      end
      esutc_pkg::ST_WD_MUL: begin
        quot_d  = quot_c;
        state_d = esutc_pkg::ST_WD_REM;
      end
      esutc_pkg::ST_WD_REM: begin
        // keep the day count in work_q for the year walk
        wday_d  = rem_c[2:0];
        yo_d    = esutc_pkg::EPOCH_YEAR_OFS;
        state_d = esutc_pkg::ST_YEAR;
      end
      esutc_pkg::ST_YEAR: begin
        if (fits_c) begin
          yday_d  = work_q[8:0];
          mon_d   = 4'd0;
          state_d = esutc_pkg::ST_MONTH;
        end else begin
          work_d = diff_c;
          yo_d   = yo_q + 8'd1;
        end
      end
      esutc_pkg::ST_MONTH: begin
        if (fits_c || (mon_q == esutc_pkg::LAST_MONTH)) begin
          mday_d  = work_q[4:0] + 5'd1;
          state_d = esutc_pkg::ST_DONE;
        end else begin
          work_d = diff_c;
          mon_d  = mon_q + 4'd1;
        end
      end
      esutc_pkg::ST_DONE: begin
        // hold until the output register is free
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = esutc_pkg::ST_IDLE;
        end
      end
      default: state_d = esutc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= esutc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    quot_q <= quot_d;
    sec_q  <= sec_d;
    min_q  <= min_d;
    hr_q   <= hr_d;
    wday_q <= wday_d;
    yo_q   <= yo_d;
    yday_q <= yday_d;
    mon_q  <= mon_d;
    mday_q <= mday_d;
    if (load_out) begin
      sec_out_q  <= sec_q;
      min_out_q  <= min_q;
      hr_out_q   <= hr_q;
      wday_out_q <= wday_q;
      yo_out_q   <= yo_q;
      yday_out_q <= yday_q;
      mon_out_q  <= mon_q;
      mday_out_q <= mday_q;
    end
  end

  assign in_ready_o         = (state_q == esutc_pkg::ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign second_o           = sec_out_q;
  assign minute_o           = min_out_q;
  assign hour_o             = hr_out_q;
  assign weekday_o          = wday_out_q;
  assign years_since_1900_o = yo_out_q;
  assign day_of_year_o      = yday_out_q;
  assign month_o            = mon_out_q;
  assign day_of_month_o     = mday_out_q;

  `ESUTC_ASSERT(a_busy_after_req, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o)
  `ESUTC_ASSERT(a_month_bound, clk_i, rst_ni, (state_q == esutc_pkg::ST_MONTH) |-> (mon_q < 4'd12))
  `ESUTC_ASSERT(a_year_bound, clk_i, rst_ni, (state_q == esutc_pkg::ST_YEAR) |-> (yo_q <= 8'd138))
  `ESUTC_ASSERT(a_time_range, clk_i, rst_ni, out_valid_o |-> ((second_o < 6'd60) && (minute_o < 6'd60) && (hour_o < 5'd24) && (weekday_o < 3'd7)))
  `ESUTC_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> (!out_valid_o && in_ready_o))

endmodule

`default_nettype wire
